// ===== src/waq_pkg.sv =====
// Shared types, codes and key function for the weekly alarm queue.
// Depends on nothing; waq_if and weekly_alarm_queue refer to it by scoped names.
package waq_pkg;

	localparam int unsigned DAYS_PER_WEEK = 7;

	// Command codes of the request beat. The unused code behaves as a peek.
	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_POP    = 2'd1;
	localparam logic [1:0] CMD_PEEK   = 2'd2;

	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_DUP   = 2'd1,
		STATUS_FULL  = 2'd2,
		STATUS_EMPTY = 2'd3
	} status_t;

	// One stored alarm. The low 17 bits form the time of day directly.
	typedef struct packed {
		logic [2:0] day;
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
	} entry_t;

	localparam int unsigned ENTRY_W = $bits(entry_t);
	localparam int unsigned TOD_W   = 17;
	localparam int unsigned KEY_W   = 20;

	typedef struct packed {
		logic [1:0] command;
		logic [2:0] alarm_day;
		logic [4:0] alarm_hour;
		logic [5:0] alarm_minute;
		logic [5:0] alarm_second;
		logic [2:0] now_day;
		logic [4:0] now_hour;
		logic [5:0] now_minute;
		logic [5:0] now_second;
	} req_t;

	typedef struct packed {
		status_t    status;
		logic [6:0] alarm_count;
		logic       head_valid;
		logic [2:0] head_day;
		logic [4:0] head_hour;
		logic [5:0] head_minute;
		logic [5:0] head_second;
	} rsp_t;

	// A three-bit weekday reduced modulo seven; only the value seven folds.
	function automatic logic [2:0] day_mod7(input logic [2:0] d);
		return (d == 3'(DAYS_PER_WEEK)) ? 3'd0 : d;
	endfunction

	// Days ahead in the top three bits, time of day below. An alarm earlier
	// today is pushed a full week ahead; one equal to now stays today.
	function automatic logic [KEY_W-1:0] fire_key(input entry_t e, input logic [2:0] now_day,
		input logic [TOD_W-1:0] now_tod);
		logic [2:0] d7;
		logic [2:0] n7;
		logic [3:0] diff;
		logic [2:0] ahead;
		logic [TOD_W-1:0] tod;
		d7 = day_mod7(e.day);
		n7 = day_mod7(now_day);
		tod = e[TOD_W-1:0];
		if (d7 < n7) begin
			diff = {1'b0, d7} + 4'(DAYS_PER_WEEK) - {1'b0, n7};
		end else begin
			diff = {1'b0, d7} - {1'b0, n7};
		end
		ahead = diff[2:0];
		if (ahead == 3'd0 && tod < now_tod) begin
			ahead = 3'(DAYS_PER_WEEK);
		end
		return {ahead, tod};
	endfunction

endpackage

// ===== src/waq_if.sv =====
// Request and response stream interfaces of the weekly alarm queue.
// Depends on waq_pkg for the payload structs.
interface waq_req_if;
	logic          valid;
	logic          ready;
	waq_pkg::req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface waq_rsp_if;
	logic          valid;
	logic          ready;
	waq_pkg::rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== src/waq_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module waq_ram #(
	parameter int unsigned WIDTH = 20,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== src/weekly_alarm_queue.sv =====
// Weekly alarm queue top level: sequencer, shared key compare and alarm table RAM.
// Depends on waq_pkg, waq_if (waq_req_if, waq_rsp_if) and waq_ram.
//
// Usage: each request beat on req carries a command (insert, pop or peek), the
// alarm to insert and the current time. Exactly one response beat on rsp
// follows, with a status, the number of stored alarms and the earliest alarm.
// The table is kept sorted by which alarm fires next as seen from the time
// given with the latest insert that stored an alarm.
// Work per command: a peek reads the head and answers, a pop shifts the table
// down by one entry, and an insert scans for a duplicate and, if the alarm is
// stored, then runs an exchange sort over the table (64 entries when full with
// the default CAPACITY). The work is done by the single key compare unit on the
// one read port of the table RAM, one pair of entries per cycle within a pass.
// One item is worked on at a time: req.ready is high only while the block is
// idle, and it stays low until the response beat has been taken, so a stalled
// receiver simply holds the block with its result on rsp.
// Reset clears the alarm count and the sequencer; the RAM needs no clearing
// since only entries below the count are ever used.
module weekly_alarm_queue #(
	parameter int unsigned CAPACITY = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	waq_req_if.sink   req,
	waq_rsp_if.source rsp
);

	localparam int unsigned AW = $clog2(CAPACITY);
	localparam int unsigned CW = $clog2(CAPACITY + 1);

	typedef enum logic [3:0] {
		S_IDLE,
		S_DUP,
		S_APPEND,
		S_LOAD,
		S_LOADW,
		S_STEP,
		S_SHIFT,
		S_HEAD_RD,
		S_HEAD_W,
		S_OUT
	} state_t;

	state_t                     state_q;
	waq_pkg::req_t              item_q;
	waq_pkg::entry_t            cur_q;
	logic [waq_pkg::KEY_W-1:0]  cur_key_q;
	logic [AW-1:0]              i_q;
	logic [CW-1:0]              j_q;
	logic [AW-1:0]              jd_q;
	logic                       vld_q;
	logic                       dup_q;
	logic [CW-1:0]              count_q;
	waq_pkg::status_t           status_q;
	waq_pkg::rsp_t              rsp_q;
	logic                       rsp_valid_q;

	logic                       ram_we;
	logic [AW-1:0]              ram_waddr;
	waq_pkg::entry_t            ram_wdata;
	logic [AW-1:0]              ram_raddr;
	logic [waq_pkg::ENTRY_W-1:0] ram_rdata;
	waq_pkg::entry_t            rd_entry;
	waq_pkg::entry_t            new_entry;
	logic [waq_pkg::TOD_W-1:0]  now_tod;
	logic [waq_pkg::KEY_W-1:0]  rd_key;
	logic                       swap;
	logic                       more;
	logic                       next_pass;

	waq_ram #(
		.WIDTH(waq_pkg::ENTRY_W),
		.DEPTH(CAPACITY)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign rd_entry  = waq_pkg::entry_t'(ram_rdata);
	assign new_entry = '{day: item_q.alarm_day, hour: item_q.alarm_hour,
		minute: item_q.alarm_minute, second: item_q.alarm_second};
	assign now_tod   = {item_q.now_hour, item_q.now_minute, item_q.now_second};

	// The shared unit: the key of the entry coming out of the RAM, compared
	// against the key of the entry held in cur_q. Equal keys also swap.
	assign rd_key = waq_pkg::fire_key(rd_entry, item_q.now_day, now_tod);
	assign swap   = !(cur_key_q < rd_key);

	// Another read is still to be issued in the scanning states.
	assign more = (j_q < count_q);
	// Another outer pass of the sort follows the one now ending.
	assign next_pass = ((CW + 1)'(i_q) + (CW + 1)'(2)) < (CW + 1)'(count_q);

	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

	// RAM port control. In the sort and the pop shift a read and a write never meet
	// at one address: the write trails the read by one entry, or two in the shift.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = cur_q;
		ram_raddr = '0;
		unique case (state_q)
			S_DUP, S_LOADW: begin
				ram_raddr = j_q[AW-1:0];
			end
			S_APPEND: begin
				ram_we    = 1'b1;
				ram_waddr = count_q[AW-1:0];
				ram_wdata = new_entry;
			end
			S_LOAD: begin
				ram_raddr = i_q;
			end
			S_STEP: begin
				ram_raddr = j_q[AW-1:0];
				if (vld_q) begin
					ram_we    = swap;
					ram_waddr = jd_q;
				end else begin
					// End of the pass: the minimum goes to its place.
					ram_we    = 1'b1;
					ram_waddr = i_q;
				end
			end
			S_SHIFT: begin
				ram_raddr = j_q[AW-1:0];
				ram_we    = vld_q;
				ram_waddr = jd_q - AW'(1);
				ram_wdata = rd_entry;
			end
			default: begin
				ram_raddr = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
			vld_q       <= 1'b0;
			dup_q       <= 1'b0;
			status_q    <= waq_pkg::STATUS_OK;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						item_q   <= req.data;
						status_q <= waq_pkg::STATUS_OK;
						dup_q    <= 1'b0;
						vld_q    <= 1'b0;
						j_q      <= '0;
						unique case (req.data.command)
							waq_pkg::CMD_INSERT: state_q <= S_DUP;
							waq_pkg::CMD_POP: begin
								j_q     <= CW'(1);
								state_q <= (count_q == '0) ? S_HEAD_RD : S_SHIFT;
								if (count_q == '0) begin
									status_q <= waq_pkg::STATUS_EMPTY;
								end
							end
							default: state_q <= S_HEAD_RD;
						endcase
					end
				end
				S_DUP: begin
					if (vld_q && rd_entry == new_entry) begin
						dup_q <= 1'b1;
					end
					vld_q <= more;
					if (more) begin
						j_q <= j_q + CW'(1);
					end else if (!vld_q) begin
						if (dup_q) begin
							status_q <= waq_pkg::STATUS_DUP;
							state_q  <= S_HEAD_RD;
						end else if (count_q == CW'(CAPACITY)) begin
							status_q <= waq_pkg::STATUS_FULL;
							state_q  <= S_HEAD_RD;
						end else begin
							state_q <= S_APPEND;
						end
					end
				end
				S_APPEND: begin
					count_q <= count_q + CW'(1);
					i_q     <= '0;
					state_q <= (count_q == '0) ? S_HEAD_RD : S_LOAD;
				end
				S_LOAD: begin
					j_q     <= CW'(i_q) + CW'(1);
					state_q <= S_LOADW;
				end
				S_LOADW: begin
					cur_q     <= rd_entry;
					cur_key_q <= rd_key;
					jd_q      <= j_q[AW-1:0];
					j_q       <= j_q + CW'(1);
					vld_q     <= 1'b1;
					state_q   <= S_STEP;
				end
				S_STEP: begin
					if (vld_q) begin
						if (swap) begin
							cur_q     <= rd_entry;
							cur_key_q <= rd_key;
						end
						vld_q <= more;
						if (more) begin
							jd_q <= j_q[AW-1:0];
							j_q  <= j_q + CW'(1);
						end
					end else begin
						i_q     <= i_q + AW'(1);
						state_q <= next_pass ? S_LOAD : S_HEAD_RD;
					end
				end
				S_SHIFT: begin
					vld_q <= more;
					if (more) begin
						jd_q <= j_q[AW-1:0];
						j_q  <= j_q + CW'(1);
					end else if (!vld_q) begin
						count_q <= count_q - CW'(1);
						state_q <= S_HEAD_RD;
					end
				end
				S_HEAD_RD: begin
					state_q <= S_HEAD_W;
				end
				S_HEAD_W: begin
					rsp_q.status      <= status_q;
					rsp_q.alarm_count <= 7'(count_q);
					rsp_q.head_valid  <= (count_q != '0);
					if (count_q != '0) begin
						rsp_q.head_day    <= rd_entry.day;
						rsp_q.head_hour   <= rd_entry.hour;
						rsp_q.head_minute <= rd_entry.minute;
						rsp_q.head_second <= rd_entry.second;
					end else begin
						rsp_q.head_day    <= '0;
						rsp_q.head_hour   <= '0;
						rsp_q.head_minute <= '0;
						rsp_q.head_second <= '0;
					end
					rsp_valid_q <= 1'b1;
					state_q     <= S_OUT;
				end
				S_OUT: begin
					if (rsp.ready) begin
						rsp_valid_q <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// The table never holds more alarms than it has room for.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("alarm count above capacity");

	// Once a request beat is taken, no other is taken until its response.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request taken while an item is in progress");

	// An empty-table pop leaves an empty table behind.
	a_empty_pop: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.data.status == waq_pkg::STATUS_EMPTY |->
		count_q == '0 && !rsp.data.head_valid)
		else $error("empty status with alarms stored");

	// The reported head matches the stored count.
	a_head_valid: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> rsp.data.head_valid == (count_q != '0))
		else $error("head valid disagrees with the alarm count");

	// Without a head, the head fields read as zero.
	a_head_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.data.head_valid |->
		rsp.data.head_day == '0 && rsp.data.head_hour == '0 &&
		rsp.data.head_minute == '0 && rsp.data.head_second == '0)
		else $error("head fields set on an empty table");

endmodule
